// File: src/lcar_pkg.sv
package lcar_pkg;

    // Port and register widths
    localparam int HALF_W      = 8;
    localparam int GAP_W       = 16;
    localparam int RAW_CODE_W  = 24;
    localparam int WEIGHT_W    = 28;
    localparam int FRAC_BITS   = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_Q4      = 1'd1;

    // Register reset values
    localparam logic [HALF_W-1:0] HALF_RESET = 8'd1;
    localparam logic [GAP_W-1:0]  GAP_RESET  = 16'd4040;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

    // What the sequencer reports for the current tick
    typedef struct packed {
        logic sck;
        logic done;
    } seq_evt_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: src/lcar_seq.sv
module lcar_seq
    import lcar_pkg::*;
#(
    parameter int DATA_BITS = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 dout_level,
    input  logic [HALF_W-1:0]    half_period_ticks,
    output seq_evt_t             evt,
    output logic [DATA_BITS-1:0] raw
);

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    localparam logic [5:0] SHIFT_LIMIT = 6'(DATA_BITS);
    localparam logic [5:0] DONE_LIMIT  = 6'(DATA_BITS + 1);
    localparam logic [DATA_BITS-1:0] SIGN_FLIP = {1'b1, {(DATA_BITS-1){1'b0}}};

    logic [1:0]           phase_reg, phase_next;
    logic [4:0]           bit_index_reg, bit_index_next;
    logic [HALF_W-1:0]    tick_reg, tick_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;

    logic                 half_over;
    logic [4:0]           idx_inc;

    // End of a half pulse; a zero half period acts as one tick
    assign half_over = ({1'b0, tick_reg} + 9'd1) >= {1'b0, half_period_ticks};
    assign idx_inc   = bit_index_reg + 5'd1;

    // Advance the serial clock sequencer by one tick
    always_comb
    begin
        phase_next     = phase_reg;
        bit_index_next = bit_index_reg;
        tick_next      = tick_reg;
        shift_next     = shift_reg;
        evt.sck        = 1'b0;
        evt.done       = 1'b0;
        case (phase_reg)
            PH_HIGH:
            begin
                evt.sck = 1'b1;
                if (half_over)
                begin
                    phase_next = PH_LOW;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next = tick_reg + 8'd1;
                end
            end
            PH_LOW:
            begin
                // sample data on the falling edge
                if (tick_reg == '0 && {1'b0, bit_index_reg} < SHIFT_LIMIT)
                begin
                    shift_next = {shift_reg[DATA_BITS-2:0], dout_level};
                end
                if (half_over)
                begin
                    tick_next = '0;
                    if ({1'b0, idx_inc} >= DONE_LIMIT || idx_inc == 5'd0)
                    begin
                        evt.done       = 1'b1;
                        phase_next     = PH_WAIT;
                        bit_index_next = '0;
                    end
                    else
                    begin
                        phase_next     = PH_HIGH;
                        bit_index_next = idx_inc;
                    end
                end
                else
                begin
                    tick_next = tick_reg + 8'd1;
                end
            end
            default:
            begin
                // wait for data low; unused codes land here too
                phase_next = PH_WAIT;
                if (!dout_level)
                begin
                    phase_next     = PH_HIGH;
                    tick_next      = '0;
                    bit_index_next = '0;
                    shift_next     = '0;
                end
            end
        endcase
    end

    // Flip the sign bit to get offset binary
    assign raw = shift_next ^ SIGN_FLIP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            bit_index_reg <= '0;
            tick_reg      <= '0;
            shift_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            bit_index_reg <= bit_index_next;
            tick_reg      <= tick_next;
            shift_reg     <= shift_next;
        end
    end

endmodule

// File: src/lcar_div.sv
module lcar_div
    import lcar_pkg::*;
#(
    parameter int DIVIDEND_W = 28
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [GAP_W-1:0]      divisor,
    output div_stat_t             stat,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [GAP_W-1:0]      rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [GAP_W-1:0]      div_reg, div_next;

    logic [GAP_W:0]        trial;
    logic [GAP_W:0]        diff;
    logic                  fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[GAP_W-1:0] : trial[GAP_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// File: src/load_cell_adc_reader_with_tare.sv
// Load cell converter reader with tare. Each request is one microsecond tick
// carrying the sampled data pin and a tare request; each gives one response
// with the serial clock level to drive, the completion flag, the last raw code
// (offset binary), whether it became the tare, and the current weight. A
// normal tick's response is registered. The tick that finishes a conversion
// above the tare, with no tare pending, starts the restoring divider, which
// retires one quotient bit per cycle, and no request is taken until the
// divider has finished. Weight = floor((raw - tare) * 16 / gap_q4), saturated to 28 bits;
// a gap_q4 of zero divides by one. Configuration is taken at any time through
// the cfg port (index 0: half_period_ticks, index 1: gap_q4) and should only
// change while no request is in flight.
module load_cell_adc_reader_with_tare
    import lcar_pkg::*;
#(
    parameter int DATA_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   dout_level,
    input  logic                   tare_request,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   sck_level,
    output logic                   sample_done,
    output logic [RAW_CODE_W-1:0]  raw_code,
    output logic                   tare_taken,
    output logic [WEIGHT_W-1:0]    weight,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DIVIDEND_W = DATA_BITS + FRAC_BITS;
    localparam int SAT_W      = (DIVIDEND_W > WEIGHT_W) ? DIVIDEND_W : WEIGHT_W;

    logic [HALF_W-1:0]     half_reg;
    logic [GAP_W-1:0]      gap_reg;
    logic [DATA_BITS-1:0]  tare_reg;
    logic                  pending_reg;
    logic [WEIGHT_W-1:0]   weight_reg;
    logic [DATA_BITS-1:0]  last_raw_reg;
    logic                  out_valid_reg;
    logic                  sck_reg;
    logic                  done_reg;
    logic                  taken_reg;

    logic                  accept;
    seq_evt_t              evt;
    logic [DATA_BITS-1:0]  raw;
    logic                  pending_now;
    logic                  div_start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [GAP_W-1:0]      divisor;
    div_stat_t             div_stat;
    logic [DIVIDEND_W-1:0] quotient;
    logic [SAT_W-1:0]      quo_ext;
    logic [WEIGHT_W-1:0]   quo_sat;

    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HALF_RESET;
            gap_reg  <= GAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HALF_PERIOD: half_reg <= cfg_data[HALF_W-1:0];
                REG_GAP_Q4:      gap_reg  <= cfg_data[GAP_W-1:0];
                default:         ;
            endcase
        end
    end

    assign in_ready = !div_stat.busy && !div_stat.done && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    lcar_seq #(
        .DATA_BITS (DATA_BITS)
    ) u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (accept),
        .dout_level        (dout_level),
        .half_period_ticks (half_reg),
        .evt               (evt),
        .raw               (raw)
    );

    // Decide tare capture or weight update on a finished conversion
    assign pending_now = pending_reg || tare_request;
    assign div_start   = accept && evt.done && !pending_now && (raw > tare_reg);
    assign dividend    = {raw - tare_reg, {FRAC_BITS{1'b0}}};
    assign divisor     = (gap_reg == '0) ? GAP_W'(1) : gap_reg;

    lcar_div #(
        .DIVIDEND_W (DIVIDEND_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // Saturate the quotient to the weight width
    assign quo_ext = SAT_W'(quotient);
    assign quo_sat = (quo_ext > SAT_W'(WEIGHT_MAX)) ? WEIGHT_MAX : quo_ext[WEIGHT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tare_reg      <= '0;
            pending_reg   <= 1'b1;
            weight_reg    <= '0;
            last_raw_reg  <= '0;
            out_valid_reg <= 1'b0;
            sck_reg       <= 1'b0;
            done_reg      <= 1'b0;
            taken_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                sck_reg       <= evt.sck;
                done_reg      <= evt.done;
                taken_reg     <= evt.done && pending_now;
                out_valid_reg <= !div_start;
                // a finished conversion always clears the pending tare
                pending_reg   <= pending_now && !evt.done;
                if (evt.done)
                begin
                    last_raw_reg <= raw;
                    if (pending_now)
                    begin
                        tare_reg <= raw;
                    end
                end
            end
            else if (div_stat.done)
            begin
                weight_reg    <= quo_sat;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign sck_level   = sck_reg;
    assign sample_done = done_reg;
    assign tare_taken  = taken_reg;
    assign raw_code    = RAW_CODE_W'(last_raw_reg);
    assign weight      = weight_reg;

    a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && div_stat.busy))
        else $error("request taken while divider busy");

    a_taken_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tare_taken |-> sample_done)
        else $error("tare taken without a finished conversion");

    a_done_clock_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sample_done |-> !sck_level)
        else $error("conversion finished with clock high");

    a_start_runs_divider: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_stat.busy && !out_valid)
        else $error("divider did not start");

endmodule

// File: test/tb_load_cell_adc_reader_with_tare.sv
`timescale 1ns / 1ps

module tb_load_cell_adc_reader_with_tare;
    import lcar_pkg::*;

    localparam int NBITS      = RAW_CODE_W;
    localparam int SETTLE     = NBITS + 16;
    localparam int LIMIT      = 600000;
    localparam int QUIET_FROM = 1000;
    localparam int QUIET_TO   = 2000;
    localparam int PLAN_ROWS  = 13;
    localparam int RUN_PHASES = 8;
    localparam int MAX_SHOWN  = 10;

    typedef enum logic [1:0] {SEQ_WAIT, SEQ_HIGH, SEQ_LOW} seq_phase_t;
    typedef enum logic [1:0] {TARE_NONE, TARE_AT_START, TARE_AT_DONE, TARE_ANYWHERE} tare_mode_t;

    // One tick report as the block returns it
    typedef struct packed {
        logic                  sck;
        logic                  done;
        logic [RAW_CODE_W-1:0] raw;
        logic                  taken;
        logic [WEIGHT_W-1:0]   wt;
    } tick_res_t;

    // One directed conversion, with the completion report pinned where obvious
    typedef struct packed {
        logic [HALF_W-1:0]     half;
        logic [GAP_W-1:0]      gap;
        logic [NBITS-1:0]      code;
        tare_mode_t            tare;
        logic                  pinned;
        logic [RAW_CODE_W-1:0] raw;
        logic                  taken;
        logic [WEIGHT_W-1:0]   wt;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   dout_level;
    logic                   tare_request;
    logic                   out_valid;
    logic                   out_ready;
    logic                   sck_level;
    logic                   sample_done;
    logic [RAW_CODE_W-1:0]  raw_code;
    logic                   tare_taken;
    logic [WEIGHT_W-1:0]    weight;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int cyc = 0;
    int errors = 0;

    tick_res_t tick_reports_due [$];
    plan_row_t plan [PLAN_ROWS];

    // Reader state as predicted
    logic [HALF_W-1:0] half_cfg;
    logic [GAP_W-1:0]  gap_cfg;
    seq_phase_t        seq_phase;
    logic [4:0]        bit_idx;
    logic [7:0]        tick_cnt;
    logic [NBITS-1:0]  shift_reg;
    logic [NBITS-1:0]  tare_val;
    logic              tare_armed;
    logic [WEIGHT_W-1:0] weight_val;
    logic [NBITS-1:0]  last_raw;

    load_cell_adc_reader_with_tare #(.DATA_BITS(NBITS)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .dout_level   (dout_level),
        .tare_request (tare_request),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sck_level    (sck_level),
        .sample_done  (sample_done),
        .raw_code     (raw_code),
        .tare_taken   (tare_taken),
        .weight       (weight),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc == LIMIT)
        begin
            $display("tb_load_cell_adc_reader_with_tare: done, errors");
            $finish;
        end
    end

    // Pause with a chance of 18 in a hundred, except in the quiet window
    function automatic bit take_pause();
        if (cyc >= QUIET_FROM && cyc < QUIET_TO)
            return 1'b0;
        return $urandom_range(0, 99) < 18;
    endfunction

    function automatic bit half_done();
        return ({1'b0, tick_cnt} + 9'd1) >= {1'b0, half_cfg};
    endfunction

    // Falling edge of a data pulse: the converter bit is sampled now
    function automatic bit bit_due();
        return seq_phase == SEQ_LOW && tick_cnt == '0 && bit_idx < NBITS;
    endfunction

    // Last low tick of the gain pulse: the read completes now
    function automatic bit finishing_tick();
        return seq_phase == SEQ_LOW && half_done() && bit_idx == NBITS;
    endfunction

    // Advance the reader by one tick and form its report
    task automatic advance_reader(input logic d, input logic t, output tick_res_t res);
        logic [NBITS-1:0]           raw;
        logic [NBITS+FRAC_BITS-1:0] scaled;
        logic [GAP_W-1:0]           divisor;
        logic [31:0]                quo;
        res = '0;
        if (t)
            tare_armed = 1'b1;
        case (seq_phase)
            SEQ_HIGH:
            begin
                res.sck = 1'b1;
                if (half_done())
                begin
                    seq_phase = SEQ_LOW;
                    tick_cnt  = '0;
                end
                else
                    tick_cnt = tick_cnt + 8'd1;
            end
            SEQ_LOW:
            begin
                if (bit_due())
                    shift_reg = {shift_reg[NBITS-2:0], d};
                if (half_done())
                begin
                    tick_cnt = '0;
                    bit_idx  = bit_idx + 5'd1;
                    if (bit_idx > NBITS || bit_idx == '0)
                    begin
                        raw       = shift_reg ^ {1'b1, {(NBITS-1){1'b0}}};
                        res.done  = 1'b1;
                        last_raw  = raw;
                        seq_phase = SEQ_WAIT;
                        bit_idx   = '0;
                        if (tare_armed)
                        begin
                            tare_val   = raw;
                            tare_armed = 1'b0;
                            res.taken  = 1'b1;
                        end
                        else if (raw > tare_val)
                        begin
                            scaled  = {raw - tare_val, {FRAC_BITS{1'b0}}};
                            divisor = (gap_cfg == '0) ? GAP_W'(1) : gap_cfg;
                            quo     = 32'(scaled) / 32'(divisor);
                            weight_val = (quo > 32'(WEIGHT_MAX)) ? WEIGHT_MAX
                                                                 : quo[WEIGHT_W-1:0];
                        end
                    end
                    else
                        seq_phase = SEQ_HIGH;
                end
                else
                    tick_cnt = tick_cnt + 8'd1;
            end
            default:
            begin
                seq_phase = SEQ_WAIT;
                if (!d)
                begin
                    seq_phase = SEQ_HIGH;
                    tick_cnt  = '0;
                    bit_idx   = '0;
                    shift_reg = '0;
                end
            end
        endcase
        res.raw = last_raw;
        res.wt  = weight_val;
    endtask

    // Offer one tick request, hold it until taken, then predict its report
    task automatic send_tick(input logic d, input logic t, input logic pinned,
                             input tick_res_t pinned_res);
        tick_res_t res;
        while (take_pause())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        dout_level   <= d;
        tare_request <= t;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        advance_reader(d, t, res);
        tick_reports_due.push_back(pinned ? pinned_res : res);
    endtask

    // Play the converter through one full read of the given code
    task automatic run_conversion(input logic [NBITS-1:0] code, input tare_mode_t mode,
                                  input logic pinned, input tick_res_t pinned_res);
        logic last;
        logic d;
        logic t;
        int   waits;
        waits = $urandom_range(0, 3);
        // hold data high while the converter is still busy
        repeat (waits)
            send_tick(1'b1, mode == TARE_ANYWHERE && $urandom_range(0, 15) == 0, 1'b0, '0);
        send_tick(1'b0, mode == TARE_AT_START, 1'b0, '0);
        // present each bit for its falling edge, noise elsewhere
        do
        begin
            last = finishing_tick();
            d = bit_due() ? code[NBITS-1-bit_idx] : 1'($urandom_range(0, 1));
            t = (mode == TARE_AT_DONE && last) ||
                (mode == TARE_ANYWHERE && $urandom_range(0, 63) == 0);
            send_tick(d, t, pinned && last, pinned_res);
        end
        while (!last);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        if (idx == REG_HALF_PERIOD)
            half_cfg = val[HALF_W-1:0];
        else
            gap_cfg = val[GAP_W-1:0];
    endtask

    // Drain the block, then load a new half period and divisor
    task automatic retune(input logic [HALF_W-1:0] half, input logic [GAP_W-1:0] gap);
        in_valid <= 1'b0;
        while (tick_reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        write_reg(REG_HALF_PERIOD, CFG_DATA_W'(half));
        write_reg(REG_GAP_Q4, CFG_DATA_W'(gap));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [NBITS-1:0] pick_code();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(NBITS-1){1'b1}}};
            1: return {1'b1, {(NBITS-1){1'b0}}};
            2: return '1;
            3: return '0;
            default: return NBITS'($urandom);
        endcase
    endfunction

    // Stimulus and prediction
    initial
    begin
        logic [HALF_W-1:0] half;
        logic [GAP_W-1:0]  gap;
        tare_mode_t        mode;
        plan_row_t         row;

        in_valid     <= 1'b0;
        dout_level   <= 1'b1;
        tare_request <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_HALF_PERIOD;
        cfg_data     <= '0;

        half_cfg   = HALF_RESET;
        gap_cfg    = GAP_RESET;
        seq_phase  = SEQ_WAIT;
        bit_idx    = '0;
        tick_cnt   = '0;
        shift_reg  = '0;
        tare_val   = '0;
        tare_armed = 1'b1;
        weight_val = '0;
        last_raw   = '0;

        // half, gap, code, tare, pinned, raw, taken, weight
        plan = '{
            // first read after reset becomes the tare
            '{8'd1, 16'd4040,  24'h800000, TARE_NONE,     1'b1, 24'h000000, 1'b1, 28'h0},
            '{8'd1, 16'd4040,  24'h7FFFFF, TARE_NONE,     1'b0, '0, 1'b0, '0},
            '{8'd1, 16'd4040,  24'h000000, TARE_NONE,     1'b0, '0, 1'b0, '0},
            // full span over a zero tare, divisor one and divisor zero
            '{8'd1, 16'd1,     24'h7FFFFF, TARE_NONE,     1'b1, 24'hFFFFFF, 1'b0, 28'hFFFFFF0},
            '{8'd1, 16'd0,     24'h7FFFFF, TARE_NONE,     1'b1, 24'hFFFFFF, 1'b0, 28'hFFFFFF0},
            // tare request on the completion tick itself
            '{8'd1, 16'd0,     24'hFFFFFF, TARE_AT_DONE,  1'b1, 24'h7FFFFF, 1'b1, 28'hFFFFFF0},
            // equal to the tare: weight held
            '{8'd1, 16'd0,     24'hFFFFFF, TARE_NONE,     1'b1, 24'h7FFFFF, 1'b0, 28'hFFFFFF0},
            '{8'd1, 16'd0,     24'h000000, TARE_NONE,     1'b1, 24'h800000, 1'b0, 28'd16},
            // half period zero, tare requested as the read starts
            '{8'd0, 16'd4040,  24'hAAAAAA, TARE_AT_START, 1'b1, 24'h2AAAAA, 1'b1, 28'd16},
            '{8'd0, 16'd4040,  24'h555555, TARE_NONE,     1'b0, '0, 1'b0, '0},
            '{8'd2, 16'd65535, 24'h123456, TARE_NONE,     1'b0, '0, 1'b0, '0},
            '{8'd2, 16'd65535, 24'hFEDCBA, TARE_ANYWHERE, 1'b0, '0, 1'b0, '0},
            '{8'd1, 16'd16,    24'h000001, TARE_NONE,     1'b0, '0, 1'b0, '0}
        };

        wait (rst_n === 1'b1);
        @(posedge clk);

        // directed conversions
        foreach (plan[i])
        begin
            row = plan[i];
            if (row.half != half_cfg || row.gap != gap_cfg)
                retune(row.half, row.gap);
            run_conversion(row.code, row.tare, row.pinned,
                           tick_res_t'{1'b0, 1'b1, row.raw, row.taken, row.wt});
        end

        // random conversions over several clock and divisor settings
        for (int p = 0; p < RUN_PHASES; p++)
        begin
            gap = GAP_W'($urandom_range(1, 8000));
            case (p)
                0: half = 8'd2;
                1: begin half = 8'd0; gap = 16'd0; end
                2: half = 8'd3;
                3: begin half = 8'd5; gap = 16'd1; end
                4: begin half = 8'd1; gap = 16'd65535; end
                default: half = HALF_W'($urandom_range(0, 3));
            endcase
            retune(half, gap);
            repeat (1)
            begin
                case ($urandom_range(0, 9))
                    0: mode = TARE_AT_START;
                    1: mode = TARE_AT_DONE;
                    2: mode = TARE_ANYWHERE;
                    default: mode = TARE_NONE;
                endcase
                run_conversion(pick_code(), mode, 1'b0, '0);
            end
        end

        // drain and let the divider settle
        in_valid <= 1'b0;
        while (tick_reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("tb_load_cell_adc_reader_with_tare: done, clean");
        else
            $display("tb_load_cell_adc_reader_with_tare: done, errors");
        $finish;
    end

    // Take tick reports and compare with the oldest prediction
    initial
    begin
        tick_res_t got;
        tick_res_t want;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready === 1'b1)
            begin
                got = {sck_level, sample_done, raw_code, tare_taken, weight};
                if (tick_reports_due.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("unexpected tick report at cycle %0d: sck %b done %b raw %h",
                                 cyc, got.sck, got.done, got.raw);
                end
                else
                begin
                    want = tick_reports_due.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= MAX_SHOWN)
                            $display({"mismatch at cycle %0d (exp/got): sck %b/%b done %b/%b",
                                      " raw %h/%h taken %b/%b weight %h/%h"},
                                     cyc, want.sck, got.sck, want.done, got.done,
                                     want.raw, got.raw, want.taken, got.taken,
                                     want.wt, got.wt);
                    end
                end
            end
            out_ready <= !take_pause();
        end
    end

endmodule
